FILE: src/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants for the mismatch-tolerant match extender.
// ----------------------------------------------------------------------------
package mte_pkg;

   localparam int FIELD_LEN_BITS = 24;
   localparam int BYTE_BITS      = 8;
   localparam int RUN_BITS       = 9;

   localparam logic [BYTE_BITS-1:0] TOLERANCE_RESET = 8'd8;

   localparam int COST_BASE    = 1;
   localparam int COST_PER_RUN = 2;

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_PAIR  = 1'b1
   } action_type;

   typedef struct packed {
      action_type                action;
      logic [FIELD_LEN_BITS-1:0] init_length;
      logic [FIELD_LEN_BITS-1:0] ref_room;
      logic [FIELD_LEN_BITS-1:0] length_limit;
      logic [BYTE_BITS-1:0]      ref_byte;
      logic [BYTE_BITS-1:0]      target_byte;
   } req_type;

   typedef struct packed {
      logic                      run_valid;
      logic [FIELD_LEN_BITS-1:0] run_position;
      logic [BYTE_BITS-1:0]      run_length;
      logic                      active;
      logic [FIELD_LEN_BITS-1:0] match_length;
      logic [FIELD_LEN_BITS-1:0] code_cost;
      logic [FIELD_LEN_BITS-1:0] mismatch_total;
   } rsp_type;

   // Classified request as it travels from front to back
   typedef struct packed {
      logic                      is_start;
      logic                      bytes_equal;
      logic [FIELD_LEN_BITS-1:0] init_length;
      logic [FIELD_LEN_BITS-1:0] ref_room;
      logic [FIELD_LEN_BITS-1:0] length_limit;
   } entry_type;

endpackage

FILE: src/mte_front.sv
// ----------------------------------------------------------------------------
// mte_front
// Accepts requests, classifies them (start or byte pair, pair match) and
// holds the classified entry until the queue takes it.
// ----------------------------------------------------------------------------
module mte_front
   import mte_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_payload,
   output logic      ent_valid,
   input  logic      ent_ready,
   output entry_type ent_data
);

   logic      valid_ff, valid_in;
   entry_type entry_ff;
   entry_type entry_in;
   logic      load;

   assign req_stall = valid_ff && !ent_ready;
   assign load      = req_valid && !req_stall;

   always_comb begin
      entry_in.is_start     = (req_payload.action == ACTION_START);
      entry_in.bytes_equal  = (req_payload.ref_byte == req_payload.target_byte);
      entry_in.init_length  = req_payload.init_length;
      entry_in.ref_room     = req_payload.ref_room;
      entry_in.length_limit = req_payload.length_limit;
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (ent_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

   assign ent_valid = valid_ff;
   assign ent_data  = entry_ff;

endmodule

FILE: src/mte_queue.sv
// ----------------------------------------------------------------------------
// mte_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module mte_queue
   import mte_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_data
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
`endif

endmodule

FILE: src/mte_back.sv
// ----------------------------------------------------------------------------
// mte_back
// Carries out classified requests on the running match counters and
// registers one response per request.
// ----------------------------------------------------------------------------
module mte_back
   import mte_pkg::*;
#(
   parameter int LENGTH_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [BYTE_BITS-1:0] csr_wdata,
   input  logic                 ent_valid,
   output logic                 ent_ready,
   input  entry_type            ent_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload
);

   localparam int LB = LENGTH_BITS;
   localparam logic [LB-1:0] LEN_MASK   = {LB{1'b1}};
   localparam logic [LB-1:0] COST_START = LB'(COST_BASE);
   localparam logic [LB:0]   COST_STEP  = (LB + 1)'(COST_PER_RUN);

   logic [BYTE_BITS-1:0] max_ff;
   logic [LB-1:0]        len_ff, len_in;
   logic [RUN_BITS-1:0]  run_ff, run_in;
   logic [LB-1:0]        cost_ff, cost_in;
   logic [LB-1:0]        mis_ff, mis_in;
   logic [LB-1:0]        room_ff, room_in;
   logic [LB-1:0]        limit_ff, limit_in;
   logic                 active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 pop;
   logic [LB-1:0]        start_len, start_room, start_limit;
   logic [LB+23:0]       start_len_w, start_room_w, start_limit_w;
   logic [LB:0]          sum_ext;
   logic [LB:0]          cost_step;
   logic [RUN_BITS-1:0]  run_inc;
   logic                 closed;
   logic [LB-1:0]        closed_pos;
   logic [LB+23:0]       pos_w, len_w, cost_w, mis_w;

   assign pop       = ent_valid && (!rsp_valid_ff || !rsp_stall);
   assign ent_ready = !rsp_valid_ff || !rsp_stall;

   // Resize the request's length fields to the internal width
   assign start_len_w   = {{LB{1'b0}}, ent_data.init_length};
   assign start_room_w  = {{LB{1'b0}}, ent_data.ref_room};
   assign start_limit_w = {{LB{1'b0}}, ent_data.length_limit};
   assign start_len     = start_len_w[LB-1:0];
   assign start_room    = start_room_w[LB-1:0];
   assign start_limit   = start_limit_w[LB-1:0];

   // length + run + 1 covers both the folded length and the reach check
   assign sum_ext   = {1'b0, len_ff} + (LB + 1)'(run_ff) + (LB + 1)'(1);
   assign cost_step = {1'b0, cost_ff} + COST_STEP;
   assign run_inc   = run_ff + RUN_BITS'(1);

   always_comb begin
      len_in     = len_ff;
      run_in     = run_ff;
      cost_in    = cost_ff;
      mis_in     = mis_ff;
      room_in    = room_ff;
      limit_in   = limit_ff;
      active_in  = active_ff;
      closed     = 1'b0;
      closed_pos = '0;
      if (ent_data.is_start) begin
         len_in    = start_len;
         room_in   = start_room;
         limit_in  = start_limit;
         cost_in   = COST_START;
         mis_in    = '0;
         run_in    = '0;
         active_in = (start_len < start_room) && (start_len < start_limit);
      end else if (active_ff) begin
         if (ent_data.bytes_equal) begin
            if (run_ff != '0) begin
               closed     = 1'b1;
               closed_pos = len_ff;
               cost_in    = (cost_step > {1'b0, LEN_MASK}) ? LEN_MASK : cost_step[LB-1:0];
               mis_in     = mis_ff + LB'(run_ff);
            end
            len_in    = sum_ext[LB-1:0];
            run_in    = '0;
            active_in = (sum_ext[LB-1:0] < room_ff) && (sum_ext[LB-1:0] < limit_ff);
         end else begin
            run_in    = run_inc;
            active_in = (run_inc <= RUN_BITS'(max_ff))
                        && (sum_ext < {1'b0, room_ff})
                        && (len_ff < limit_ff);
         end
      end
   end

   assign pos_w  = {24'd0, closed_pos};
   assign len_w  = {24'd0, len_in};
   assign cost_w = {24'd0, cost_in};
   assign mis_w  = {24'd0, mis_in};

   always_comb begin
      rsp_in.run_valid      = closed;
      rsp_in.run_position   = pos_w[FIELD_LEN_BITS-1:0];
      rsp_in.run_length     = closed ? run_ff[BYTE_BITS-1:0] : '0;
      rsp_in.active         = active_in;
      rsp_in.match_length   = len_w[FIELD_LEN_BITS-1:0];
      rsp_in.code_cost      = cost_w[FIELD_LEN_BITS-1:0];
      rsp_in.mismatch_total = mis_w[FIELD_LEN_BITS-1:0];
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= TOLERANCE_RESET;
         len_ff       <= '0;
         run_ff       <= '0;
         cost_ff      <= COST_START;
         mis_ff       <= '0;
         room_ff      <= '0;
         limit_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
         if (pop) begin
            len_ff    <= len_in;
            run_ff    <= run_in;
            cost_ff   <= cost_in;
            mis_ff    <= mis_in;
            room_ff   <= room_in;
            limit_ff  <= limit_in;
            active_ff <= active_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_active_below_limit: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (len_ff < limit_ff))
      else $error("active match at or beyond its length limit");

   a_cost_nonzero: assert property (@(posedge clock) disable iff (reset)
      cost_ff != '0)
      else $error("code cost dropped to zero");

   a_closed_run_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.run_valid) |-> (rsp_ff.run_length != '0))
      else $error("closed mismatch run reported with zero length");
`endif

endmodule

FILE: src/mismatch_tolerant_match_extender_top.sv
// ----------------------------------------------------------------------------
// mismatch_tolerant_match_extender_top
// Grows one candidate match byte pair by byte pair, tolerating short runs of
// mismatching bytes.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req_payload): a start request
// loads start length, reference room and length limit, sets the cost to 1 and
// clears the mismatch counter; a pair request delivers one aligned byte pair.
// Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one
// response per request, in request order, with any closed mismatch run and
// the running match status.
// csr_we / csr_wdata write the mismatch run tolerance; write it only while idle.
// A response passes the front register, the two-entry queue and the response
// register in the back end. Throughput is one request per cycle while the
// response channel does not stall; the back end updates its counters for
// each request as it pops it. A stalled response holds the back end; the
// queue and the front register then fill and req_stall rises. Reset is
// synchronous: it empties the pipeline, sets the run tolerance to 8, cost to
// 1 and the match inactive.
// ----------------------------------------------------------------------------
module mismatch_tolerant_match_extender_top
   import mte_pkg::*;
#(
   parameter int LENGTH_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_we,
   input  logic [BYTE_BITS-1:0] csr_wdata
);

   logic      front_valid, front_ready;
   entry_type front_data;
   logic      queue_valid, queue_ready;
   entry_type queue_data;

   mte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .ent_valid   (front_valid),
      .ent_ready   (front_ready),
      .ent_data    (front_data)
   );

   mte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_data)
   );

   mte_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .ent_valid   (queue_valid),
      .ent_ready   (queue_ready),
      .ent_data    (queue_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/sv/match_extension_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// match_extension_sb_pkg
// Scoreboard for the mismatch-tolerant match extender: tracks the match
// state per accepted request and checks every response in order.
// ----------------------------------------------------------------------------
package match_extension_sb_pkg;
   import mte_pkg::*;

   localparam logic [FIELD_LEN_BITS-1:0] LEN_ALL_ONES = '1;
   localparam int MAX_PRINTED = 60;

   class match_extension_scoreboard;
      rsp_type                   expected_status[$];
      logic [BYTE_BITS-1:0]      run_tolerance;
      logic [FIELD_LEN_BITS-1:0] length_count;
      logic [FIELD_LEN_BITS-1:0] ref_room;
      logic [FIELD_LEN_BITS-1:0] length_limit;
      logic [FIELD_LEN_BITS-1:0] cost;
      logic [FIELD_LEN_BITS-1:0] mismatch_total;
      logic [RUN_BITS-1:0]       run_count;
      logic                      active;
      int                        errors;
      int                        checked;
      int                        starts;
      int                        pairs;
      int                        runs_closed;

      function new();
         run_tolerance  = TOLERANCE_RESET;
         length_count   = '0;
         ref_room       = '0;
         length_limit   = '0;
         cost           = FIELD_LEN_BITS'(COST_BASE);
         mismatch_total = '0;
         run_count      = '0;
         active         = 1'b0;
         errors         = 0;
         checked        = 0;
         starts         = 0;
         pairs          = 0;
         runs_closed    = 0;
      endfunction

      function void set_run_tolerance(logic [BYTE_BITS-1:0] value);
         run_tolerance = value;
      endfunction

      function bit is_active();
         return active;
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      function bit can_extend();
         logic [FIELD_LEN_BITS:0] reach;
         reach = length_count + run_count;
         return (run_count <= run_tolerance) && (reach < ref_room)
            && (length_count < length_limit);
      endfunction

      // Advance the match state by one request; return 0 if it was ignored.
      function bit note_request(req_type item);
         rsp_type want;
         bit      effective;
         want      = '0;
         effective = 1'b1;
         if (item.action == ACTION_START) begin
            length_count   = item.init_length;
            ref_room       = item.ref_room;
            length_limit   = item.length_limit;
            cost           = FIELD_LEN_BITS'(COST_BASE);
            mismatch_total = '0;
            run_count      = '0;
            active         = can_extend();
            starts++;
         end else if (active) begin
            if (item.ref_byte == item.target_byte) begin
               if (run_count != 0) begin
                  want.run_valid    = 1'b1;
                  want.run_position = length_count;
                  want.run_length   = run_count[BYTE_BITS-1:0];
                  if (cost > LEN_ALL_ONES - FIELD_LEN_BITS'(COST_PER_RUN)) begin
                     cost = LEN_ALL_ONES;
                  end else begin
                     cost = cost + FIELD_LEN_BITS'(COST_PER_RUN);
                  end
                  mismatch_total = mismatch_total + run_count;
                  length_count   = length_count + run_count;
                  run_count      = '0;
               end
               length_count = length_count + 1'b1;
            end else begin
               run_count = run_count + 1'b1;
            end
            active = can_extend();
            pairs++;
         end else begin
            effective = 1'b0;
         end
         want.active         = active;
         want.match_length   = length_count;
         want.code_cost      = cost;
         want.mismatch_total = mismatch_total;
         expected_status.push_back(want);
         return effective;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= MAX_PRINTED) begin
            $display("[%0t] response %0d: %s is 0x%0h, expected 0x%0h",
                     $time, checked, what, got, want);
         end
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_status.size() == 0) begin
            report("response with nothing pending", 1, 0);
            return;
         end
         want = expected_status.pop_front();
         checked++;
         if (want.run_valid) runs_closed++;
         if (got.run_valid !== want.run_valid)
            report("run_valid", got.run_valid, want.run_valid);
         if (got.run_position !== want.run_position)
            report("run_position", got.run_position, want.run_position);
         if (got.run_length !== want.run_length)
            report("run_length", got.run_length, want.run_length);
         if (got.active !== want.active)
            report("active", got.active, want.active);
         if (got.match_length !== want.match_length)
            report("match_length", got.match_length, want.match_length);
         if (got.code_cost !== want.code_cost)
            report("code_cost", got.code_cost, want.code_cost);
         if (got.mismatch_total !== want.mismatch_total)
            report("mismatch_total", got.mismatch_total, want.mismatch_total);
      endtask

      task flag_leftovers();
         while (expected_status.size() != 0) begin
            void'(expected_status.pop_front());
            report("response never arrived", 0, 1);
         end
      endtask
   endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for mismatch_tolerant_match_extender_top: directed start and
// byte-pair requests, then random match extensions under several run
// tolerance settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import mte_pkg::*;
   import match_extension_sb_pkg::*;

   typedef logic [FIELD_LEN_BITS-1:0] len_type;

   localparam int RESET_CYCLES = 7;
   localparam int PHASE_ITEMS  = 330;
   localparam int QUIET_LIMIT  = 400;
   localparam int DRAIN_CYCLES = 8;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_we      = 1'b0;
   logic [BYTE_BITS-1:0] csr_wdata   = '0;

   match_extension_scoreboard sb = new();
   bit steady          = 1'b0;
   int effective_items = 0;
   int settings        = 0;

   mismatch_tolerant_match_extender_top #(
      .LENGTH_BITS (FIELD_LEN_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic req_type start_item(len_type init_len, len_type room, len_type limit);
      req_type item;
      item.action       = ACTION_START;
      item.init_length  = init_len;
      item.ref_room     = room;
      item.length_limit = limit;
      item.ref_byte     = BYTE_BITS'($urandom);
      item.target_byte  = BYTE_BITS'($urandom);
      return item;
   endfunction

   // Ignored length fields carry random bits; a mismatch flips at least one bit.
   function automatic req_type pair_item(bit same);
      req_type item;
      item.action       = ACTION_PAIR;
      item.init_length  = len_type'($urandom);
      item.ref_room     = len_type'($urandom);
      item.length_limit = len_type'($urandom);
      item.ref_byte     = BYTE_BITS'($urandom);
      item.target_byte  = same ? item.ref_byte
                               : item.ref_byte ^ BYTE_BITS'($urandom_range(1, 255));
      return item;
   endfunction

   task automatic send_request(req_type item);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sb.note_request(item)) effective_items++;
   endtask

   // 'm' sends a matching pair, anything else a mismatching one.
   task automatic send_pattern(string pattern);
      for (int i = 0; i < pattern.len(); i++) begin
         send_request(pair_item(pattern[i] == "m"));
      end
   endtask

   task automatic write_run_tolerance(logic [BYTE_BITS-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_run_tolerance(value);
      settings++;
   endtask

   task automatic run_directed();
      send_pattern("mx");
      send_request(start_item(len_type'(10), len_type'(10), len_type'(100)));
      send_pattern("m");
      send_request(start_item(len_type'(5), len_type'(100), len_type'(5)));
      send_request(start_item(LEN_ALL_ONES, LEN_ALL_ONES, LEN_ALL_ONES));
      send_request(start_item(len_type'(0), len_type'(20), len_type'(7)));
      send_pattern("mxxxmxmm");
      send_request(start_item(len_type'(0), len_type'(100), len_type'(100)));
      send_pattern("xxxxxxxxx");
      send_request(start_item(len_type'(0), len_type'(3), len_type'(100)));
      send_pattern("mxx");
   endtask

   // One well-formed match: matching stretches and mismatch runs around the
   // tolerated length, sometimes cut short, sometimes followed by stray pairs.
   task automatic extend_match();
      int      base;
      int      cut;
      int      sent;
      int      good;
      int      bad;
      len_type room;
      len_type limit;
      if ($urandom_range(0, 15) == 0) begin
         base = $urandom_range(0, int'(LEN_ALL_ONES) - 400);
      end else begin
         base = $urandom_range(0, 64);
      end
      room  = ($urandom_range(0, 7) == 0) ? LEN_ALL_ONES
                                          : len_type'(base + $urandom_range(0, 160));
      limit = ($urandom_range(0, 7) == 0) ? LEN_ALL_ONES
                                          : len_type'(base + $urandom_range(0, 160));
      send_request(start_item(len_type'(base), room, limit));
      cut  = $urandom_range(4, 200);
      sent = 0;
      while (sb.is_active() && sent < cut) begin
         good = $urandom_range(1, 8);
         for (int k = 0; k < good && sb.is_active(); k++) begin
            send_request(pair_item(1'b1));
            sent++;
         end
         case ($urandom_range(0, 3))
            0: begin
               bad = sb.run_tolerance;
            end
            1: begin
               bad = sb.run_tolerance + 1;
            end
            default: begin
               bad = $urandom_range(0, sb.run_tolerance);
            end
         endcase
         for (int k = 0; k < bad && sb.is_active(); k++) begin
            send_request(pair_item(1'b0));
            sent++;
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) send_request(pair_item($urandom_range(0, 1) == 1));
      end
   endtask

   task automatic run_random(int target);
      int goal;
      int kind;
      goal = effective_items + target;
      while (effective_items < goal) begin
         steady = ($urandom_range(0, 7) == 0);
         kind   = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 4)) send_request(pair_item($urandom_range(0, 1) == 1));
         end else if (kind == 1) begin
            send_request(start_item(len_type'($urandom), len_type'($urandom),
                                    len_type'($urandom)));
            repeat ($urandom_range(0, 3)) send_request(pair_item($urandom_range(0, 3) != 0));
         end else begin
            extend_match();
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
   end

   // Response side: hold stall for a random number of cycles before each response.
   initial begin
      forever begin
         int gap;
         gap = steady ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no request or response moved for %0d cycles", QUIET_LIMIT);
      $display("mismatch_tolerant_match_extender_top regression: fail");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      write_run_tolerance(8'd0);
      run_random(PHASE_ITEMS);
      write_run_tolerance(8'd255);
      run_random(PHASE_ITEMS);
      write_run_tolerance(8'd1);
      run_random(PHASE_ITEMS);
      write_run_tolerance(BYTE_BITS'($urandom_range(2, 254)));
      run_random(PHASE_ITEMS);
      write_run_tolerance(TOLERANCE_RESET);
      run_random(PHASE_ITEMS);
      write_run_tolerance(BYTE_BITS'($urandom_range(2, 254)));
      run_random(PHASE_ITEMS);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.flag_leftovers();
      $display("covered %0d starts and %0d live pairs over %0d run tolerance settings",
               sb.starts, sb.pairs, settings);
      $display("checked %0d responses, %0d closed mismatch runs, %0d mismatches",
               sb.checked, sb.runs_closed, sb.errors);
      if (sb.errors == 0) begin
         $display("mismatch_tolerant_match_extender_top regression: pass");
      end else begin
         $display("mismatch_tolerant_match_extender_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: mismatch_tolerant_match_extender_top.f
src/mte_pkg.sv
src/mte_front.sv
src/mte_queue.sv
src/mte_back.sv
src/mismatch_tolerant_match_extender_top.sv
tb/sv/match_extension_sb_pkg.sv
tb/sv/tb.sv
